FILE: src/fcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcp_pkg: shared types for the framed command parser
// Phase, status and register codes, the result word, the config bundle and
// the byte-wide reflected CRC-CCITT update.
// ----------------------------------------------------------------------------
package fcp_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_FIRST  = 3'd0,
    REG_START_SECOND = 3'd1,
    REG_MAX_RLEN     = 3'd2,
    REG_MAX_DLEN     = 3'd3
  } fcp_reg_e;

  // parse phases
  typedef enum logic [3:0] {
    PH_WAIT_A  = 4'd0,
    PH_WAIT_B  = 4'd1,
    PH_REQ     = 4'd2,
    PH_ERR     = 4'd3,
    PH_CMD     = 4'd4,
    PH_RLEN_LO = 4'd5,
    PH_RLEN_HI = 4'd6,
    PH_DLEN    = 4'd7,
    PH_DATA    = 4'd8,
    PH_CRC_LO  = 4'd9,
    PH_CRC_HI  = 4'd10
  } fcp_phase_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } fcp_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_RLEN = 2'd1,
    ST_BAD_DLEN = 2'd2,
    ST_BAD_CRC  = 2'd3
  } fcp_status_e;

  typedef struct packed {
    logic [7:0]  start_first;
    logic [7:0]  start_second;
    logic [15:0] max_rlen;
    logic [7:0]  max_dlen;
  } fcp_cfg_t;

  typedef struct packed {
    fcp_kind_e   kind;
    fcp_status_e status;
    logic [7:0]  request_id;
    logic [7:0]  header_error;
    logic [7:0]  command_id;
    logic [15:0] random_length;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
  } fcp_res_t;

  // fold one byte into the reflected CRC, LSB first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/fcp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcp_if: stream channels of the framed command parser
// fcp_byte_if moves one received byte per word; fcp_res_if moves one result.
// ----------------------------------------------------------------------------
interface fcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fcp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  request_id;
  logic [7:0]  header_error;
  logic [7:0]  command_id;
  logic [15:0] random_length;
  logic [7:0]  payload_length;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;

  modport source (output valid, output kind, output status, output request_id,
                  output header_error, output command_id, output random_length,
                  output payload_length, output payload_byte,
                  output payload_index, input ready);
  modport sink   (input valid, input kind, input status, input request_id,
                  input header_error, input command_id, input random_length,
                  input payload_length, input payload_byte,
                  input payload_index, output ready);
endinterface
`default_nettype wire

FILE: src/fcp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcp_cfg_regs: configuration registers
// Marker bytes and length limits, written through a plain write port.
// ----------------------------------------------------------------------------
module fcp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fcp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcp_pkg::CfgDataW-1:0] cfg_data_i,
  output fcp_pkg::fcp_cfg_t            cfg_o
);

  fcp_pkg::fcp_cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcp_pkg::REG_START_FIRST:  cfg_d.start_first  = cfg_data_i[7:0];
        fcp_pkg::REG_START_SECOND: cfg_d.start_second = cfg_data_i[7:0];
        fcp_pkg::REG_MAX_RLEN:     cfg_d.max_rlen     = cfg_data_i;
        fcp_pkg::REG_MAX_DLEN:     cfg_d.max_dlen     = cfg_data_i[7:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= 8'h00;
      cfg_q.start_second <= 8'h00;
      cfg_q.max_rlen     <= 16'hFFFF;
      cfg_q.max_dlen     <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: src/fcp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcp_parser: frame state machine and CRC
// Updates the phase on each accepted word and forms at most one result for it.
// ----------------------------------------------------------------------------
module fcp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcp_pkg::fcp_cfg_t cfg_i,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output fcp_pkg::fcp_res_t res_o
);

  fcp_pkg::fcp_phase_e phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  req_q, req_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] rlen_q, rlen_d;

  logic [15:0] crc_next;
  logic [15:0] rlen_full;
  logic [7:0]  pos_inc;
  logic        rlen_bad;
  logic        dlen_bad;
  logic [7:0]  plen;
  logic [7:0]  pbyte;
  logic [7:0]  pidx;
  fcp_pkg::fcp_kind_e   kind;
  fcp_pkg::fcp_status_e status;

  assign crc_next  = fcp_pkg::crc_feed(crc_q, byte_i);
  assign rlen_full = {byte_i, rlen_q[7:0]};
  assign pos_inc   = pos_q + 8'd1;
  assign rlen_bad  = rlen_full > cfg_i.max_rlen;
  assign dlen_bad  = byte_i > cfg_i.max_dlen;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      unique case (phase_q)
        fcp_pkg::PH_WAIT_A: begin
          if (byte_i == cfg_i.start_first) phase_d = fcp_pkg::PH_WAIT_B;
        end
        fcp_pkg::PH_WAIT_B: begin
          priority if (byte_i == cfg_i.start_second) phase_d = fcp_pkg::PH_REQ;
          else if (byte_i == cfg_i.start_first)      phase_d = fcp_pkg::PH_WAIT_B;
          else                                       phase_d = fcp_pkg::PH_WAIT_A;
        end
        fcp_pkg::PH_REQ:     phase_d = fcp_pkg::PH_ERR;
        fcp_pkg::PH_ERR:     phase_d = fcp_pkg::PH_CMD;
        fcp_pkg::PH_CMD:     phase_d = fcp_pkg::PH_RLEN_LO;
        fcp_pkg::PH_RLEN_LO: phase_d = fcp_pkg::PH_RLEN_HI;
        fcp_pkg::PH_RLEN_HI: begin
          phase_d = rlen_bad ? fcp_pkg::PH_WAIT_A : fcp_pkg::PH_DLEN;
        end
        fcp_pkg::PH_DLEN: begin
          priority if (dlen_bad)    phase_d = fcp_pkg::PH_WAIT_A;
          else if (byte_i == 8'd0)  phase_d = fcp_pkg::PH_CRC_LO;
          else                      phase_d = fcp_pkg::PH_DATA;
        end
        fcp_pkg::PH_DATA: begin
          if (pos_inc >= len_q) phase_d = fcp_pkg::PH_CRC_LO;
        end
        fcp_pkg::PH_CRC_LO: phase_d = fcp_pkg::PH_CRC_HI;
        fcp_pkg::PH_CRC_HI: phase_d = fcp_pkg::PH_WAIT_A;
        default:            phase_d = fcp_pkg::PH_WAIT_A;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    pos_d       = pos_q;
    len_d       = len_q;
    req_d       = req_q;
    err_d       = err_q;
    cmd_d       = cmd_q;
    rlen_d      = rlen_q;
    res_valid_o = 1'b0;
    kind        = fcp_pkg::KIND_END;
    status      = fcp_pkg::ST_OK;
    plen        = len_q;
    pbyte       = 8'h00;
    pidx        = 8'h00;
    if (take_i) begin
      unique case (phase_q)
        fcp_pkg::PH_REQ: begin
          req_d = byte_i;
          len_d = 8'h00;
          crc_d = fcp_pkg::crc_feed(fcp_pkg::CrcInit, byte_i);
        end
        fcp_pkg::PH_ERR: begin
          err_d = byte_i;
          crc_d = crc_next;
        end
        fcp_pkg::PH_CMD: begin
          cmd_d = byte_i;
          crc_d = crc_next;
        end
        fcp_pkg::PH_RLEN_LO: begin
          rlen_d = {8'h00, byte_i};
          crc_d  = crc_next;
        end
        fcp_pkg::PH_RLEN_HI: begin
          rlen_d = rlen_full;
          crc_d  = crc_next;
          if (rlen_bad) begin
            res_valid_o = 1'b1;
            status      = fcp_pkg::ST_BAD_RLEN;
            plen        = 8'h00;
          end
        end
        fcp_pkg::PH_DLEN: begin
          len_d = byte_i;
          if (dlen_bad) begin
            res_valid_o = 1'b1;
            status      = fcp_pkg::ST_BAD_DLEN;
            plen        = byte_i;
          end else begin
            crc_d = crc_next;
            pos_d = 8'h00;
          end
        end
        fcp_pkg::PH_DATA: begin
          res_valid_o = 1'b1;
          kind        = fcp_pkg::KIND_DATA;
          pbyte       = byte_i;
          pidx        = pos_q;
          crc_d       = crc_next;
          pos_d       = pos_inc;
        end
        fcp_pkg::PH_CRC_LO: crc_lo_d = byte_i;
        fcp_pkg::PH_CRC_HI: begin
          res_valid_o = 1'b1;
          status      = ({byte_i, crc_lo_q} != crc_q) ? fcp_pkg::ST_BAD_CRC
                                                      : fcp_pkg::ST_OK;
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
    res_o.kind           = kind;
    res_o.status         = status;
    res_o.request_id     = req_d;
    res_o.header_error   = err_d;
    res_o.command_id     = cmd_d;
    res_o.random_length  = rlen_d;
    res_o.payload_length = plen;
    res_o.payload_byte   = pbyte;
    res_o.payload_index  = pidx;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcp_pkg::PH_WAIT_A;
      pos_q   <= 8'h00;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // header and CRC holding registers
  always_ff @(posedge clk_i) begin
    crc_q    <= crc_d;
    crc_lo_q <= crc_lo_d;
    len_q    <= len_d;
    req_q    <= req_d;
    err_q    <= err_d;
    cmd_q    <= cmd_d;
    rlen_q   <= rlen_d;
  end

  // a data phase is entered only with a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == fcp_pkg::PH_DATA |-> len_q != 8'h00)
    else $error("data phase with zero length");

endmodule
`default_nettype wire

FILE: src/fcp_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcp_out_buf: result register with skid entry
// Holds up to two results so input words keep flowing while one waits.
// ----------------------------------------------------------------------------
module fcp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fcp_pkg::fcp_res_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fcp_pkg::fcp_res_t data_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  fcp_pkg::fcp_res_t main_q, main_d;
  fcp_pkg::fcp_res_t skid_q, skid_d;
  logic              pop;

  assign pop = main_v_q && ready_i;

  // steer pushes and refill from the skid entry
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    priority if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (main_v_q && !pop) begin
      if (push_i) begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else begin
      main_v_d = push_i;
      if (push_i) main_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  // skid entry never fills ahead of the main entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry valid while main entry empty");

  // no push while both entries are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("result pushed into full buffer");

  // a stalled pair of results keeps both entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !ready_i) |=> (skid_v_q && main_v_q))
    else $error("buffered result lost under stall");

endmodule
`default_nettype wire

FILE: src/framed_command_parser_crc16_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_command_parser_crc16_core: framed command parser with CRC-16 check
// Hunts for a two-byte marker, reads the header, streams payload bytes and
// reports a frame end with the CRC-CCITT (reflected) check status, or a length error.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the output buffer is not full:
// the phase machine and the byte-wide CRC update finish within the cycle the
// word is accepted, and any result it causes is registered into the output
// buffer. With two result entries there, input ready drops only when both
// entries hold results that the consumer has not taken; a single stalled
// result never blocks the input. Payload bytes are emitted as they arrive,
// so discard them unless the following frame end reports ok. No clearing
// pass follows reset. Write configuration only while the block is idle.
module framed_command_parser_crc16_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fcp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcp_pkg::CfgDataW-1:0] cfg_data_i,
  fcp_byte_if.sink                     in_i,
  fcp_res_if.source                    out_o
);

  fcp_pkg::fcp_cfg_t cfg;
  fcp_pkg::fcp_res_t res;
  fcp_pkg::fcp_res_t out_data;
  logic              res_valid;
  logic              buf_full;
  logic              take;

  assign in_i.ready = !buf_full;
  assign take       = in_i.valid && !buf_full;

  fcp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .byte_i      (in_i.in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fcp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (out_data)
  );

  // drive the result channel
  assign out_o.kind           = out_data.kind;
  assign out_o.status         = out_data.status;
  assign out_o.request_id     = out_data.request_id;
  assign out_o.header_error   = out_data.header_error;
  assign out_o.command_id     = out_data.command_id;
  assign out_o.random_length  = out_data.random_length;
  assign out_o.payload_length = out_data.payload_length;
  assign out_o.payload_byte   = out_data.payload_byte;
  assign out_o.payload_index  = out_data.payload_index;

endmodule
`default_nettype wire
